// ===== src/kmp_pkg.sv =====
`timescale 1ns / 1ps

package kmp_pkg;

  localparam int MAX_PATTERN = 64;
  localparam int INDEX_BITS  = 32;
  localparam int POS_W       = 32;
  localparam int BYTE_W      = 8;
  localparam int CMD_W       = 2;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int ADDR_W      = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int IDX1_W      = INDEX_BITS + 1;

  localparam int OUT_BITS    = 1 + POS_W + 1 + 1;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TEXT   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  localparam int OP_W = 2;
  localparam logic [OP_W-1:0] OP_NOP    = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_TEXT   = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] data;
  } kmp_item_t;

endpackage

// ===== src/kmp_stream_matcher.sv =====
`timescale 1ns / 1ps
// Words without a table search go from idle straight to the result register;
// searching pattern and text words pass the compare state, falling back along
// the failure table per mismatch (registered reads). One word per cycle enters
// a 4-deep queue unless full; the matcher pops only when idle with output free.
// Reset (rst_n low, synchronous) empties the queue and result register and
// clears pattern length, search state and index; stores are not cleared.

module kmp_stream_matcher import kmp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [BYTE_W-1:0]      in_tdata,   // data_byte
  input  logic [CMD_W-1:0]       in_tuser,   // command
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // match_found, match_position[31:0],
                                             // search_done, pattern_overflow
);

  logic      q_valid;
  logic      q_ready;
  kmp_item_t q_item;

  kmp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item)
  );

  kmp_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== src/kmp_front.sv =====
`timescale 1ns / 1ps

module kmp_front import kmp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [BYTE_W-1:0] in_tdata,   // data_byte
  input  logic [CMD_W-1:0]  in_tuser,   // command
  output logic              q_valid,
  input  logic              q_ready,
  output kmp_item_t         q_item
);

  kmp_item_t           mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                push, pop;
  kmp_item_t           item_in;

  always_comb begin
    item_in.data = in_tdata;
    case (in_tuser)
      CMD_APPEND: item_in.op = OP_APPEND;
      CMD_TEXT:   item_in.op = OP_TEXT;
      CMD_CLEAR:  item_in.op = OP_CLEAR;
      default:    item_in.op = OP_NOP;
    endcase
  end

  assign in_tready = (cnt_r != QCNT_W'(QDEPTH));
  assign q_valid   = (cnt_r != '0);
  assign q_item    = mem_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = q_valid && q_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

// ===== src/kmp_engine.sv =====
`timescale 1ns / 1ps

module kmp_engine import kmp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  output logic                   q_ready,
  input  kmp_item_t              q_item,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_CMP  = 1'b1;

  logic [BYTE_W-1:0]     pat_mem  [MAX_PATTERN];
  logic [LEN_W-1:0]      fail_mem [MAX_PATTERN];
  logic [BYTE_W-1:0]     pat_q;
  logic [LEN_W-1:0]      fail_q;

  logic                  state_r, state_nxt;
  logic [OP_W-1:0]       op_r, op_nxt;
  logic [BYTE_W-1:0]     byte_r, byte_nxt;
  logic [LEN_W-1:0]      len_r, len_nxt;
  logic [LEN_W-1:0]      plen_r, plen_nxt;
  logic [LEN_W-1:0]      bpl_r, bpl_nxt;
  logic [LEN_W-1:0]      ml_r, ml_nxt;
  logic [INDEX_BITS-1:0] ti_r, ti_nxt;
  logic                  found_r, found_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_found_r, out_found_nxt;
  logic [POS_W-1:0]      out_pos_r, out_pos_nxt;
  logic                  out_done_r, out_done_nxt;
  logic                  out_ovf_r, out_ovf_nxt;

  logic                  slot_free;
  logic [LEN_W-1:0]      rd_len;
  logic [LEN_W-1:0]      rd_len_m1;
  logic                  we;
  logic                  do_app, do_txt;
  logic [LEN_W-1:0]      res_len;
  logic [LEN_W-1:0]      start_len;
  logic                  hit;
  logic [IDX1_W-1:0]     idx1;
  logic [IDX1_W-1:0]     plen_ext;
  logic [INDEX_BITS-1:0] pos;

  assign slot_free = !out_valid_r || out_tready;
  assign rd_len_m1 = rd_len - LEN_W'(1);
  assign hit       = (pat_q == byte_r);
  assign idx1      = IDX1_W'(ti_r) + IDX1_W'(1);
  assign plen_ext  = IDX1_W'(plen_r);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    byte_nxt      = byte_r;
    len_nxt       = len_r;
    plen_nxt      = plen_r;
    bpl_nxt       = bpl_r;
    ml_nxt        = ml_r;
    ti_nxt        = ti_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_found_nxt = out_found_r;
    out_pos_nxt   = out_pos_r;
    out_done_nxt  = out_done_r;
    out_ovf_nxt   = out_ovf_r;
    q_ready       = 1'b0;
    rd_len        = len_r;
    we            = 1'b0;
    do_app        = 1'b0;
    do_txt        = 1'b0;
    res_len       = '0;
    start_len     = '0;
    pos           = '0;

    case (state_r)
      ST_IDLE: begin
        q_ready = slot_free;
        if (q_valid && slot_free) begin
          op_nxt   = q_item.op;
          byte_nxt = q_item.data;
          case (q_item.op)
            OP_APPEND: begin
              if (plen_r >= LEN_W'(MAX_PATTERN)) begin
                out_valid_nxt = 1'b1;
                out_found_nxt = 1'b0;
                out_pos_nxt   = '0;
                out_done_nxt  = found_r;
                out_ovf_nxt   = 1'b1;
              end else if (plen_r == '0) begin
                do_app  = 1'b1;
                res_len = '0;
              end else begin
                start_len = (bpl_r >= plen_r) ? '0 : bpl_r;
                len_nxt   = start_len;
                rd_len    = start_len;
                state_nxt = ST_CMP;
              end
            end
            OP_TEXT: begin
              if (found_r) begin
                out_valid_nxt = 1'b1;
                out_found_nxt = 1'b0;
                out_pos_nxt   = '0;
                out_done_nxt  = 1'b1;
                out_ovf_nxt   = 1'b0;
              end else if (plen_r == '0) begin
                out_valid_nxt = 1'b1;
                out_found_nxt = 1'b1;
                out_pos_nxt   = POS_W'(ti_r);
                out_done_nxt  = 1'b0;
                out_ovf_nxt   = 1'b0;
                found_nxt     = 1'b1;
                if (ti_r != '1) begin
                  ti_nxt = ti_r + INDEX_BITS'(1);
                end
              end else begin
                start_len = (ml_r >= plen_r) ? '0 : ml_r;
                len_nxt   = start_len;
                rd_len    = start_len;
                state_nxt = ST_CMP;
              end
            end
            OP_CLEAR: begin
              plen_nxt      = '0;
              bpl_nxt       = '0;
              ml_nxt        = '0;
              ti_nxt        = '0;
              found_nxt     = 1'b0;
              out_valid_nxt = 1'b1;
              out_found_nxt = 1'b0;
              out_pos_nxt   = '0;
              out_done_nxt  = found_r;
              out_ovf_nxt   = 1'b0;
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_found_nxt = 1'b0;
              out_pos_nxt   = '0;
              out_done_nxt  = found_r;
              out_ovf_nxt   = 1'b0;
            end
          endcase
        end
      end
      ST_CMP: begin
        if (len_r != '0 && !hit) begin
          len_nxt = (fail_q < len_r) ? fail_q : '0;
          rd_len  = len_nxt;
        end else begin
          res_len   = len_r + LEN_W'(hit);
          state_nxt = ST_IDLE;
          if (op_r == OP_APPEND) begin
            do_app = 1'b1;
          end else begin
            do_txt = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (do_app) begin
      we            = 1'b1;
      bpl_nxt       = res_len;
      plen_nxt      = plen_r + LEN_W'(1);
      ml_nxt        = '0;
      ti_nxt        = '0;
      out_valid_nxt = 1'b1;
      out_found_nxt = 1'b0;
      out_pos_nxt   = '0;
      out_done_nxt  = found_r;
      out_ovf_nxt   = 1'b0;
    end

    if (do_txt) begin
      out_valid_nxt = 1'b1;
      out_found_nxt = 1'b0;
      out_pos_nxt   = '0;
      out_done_nxt  = 1'b0;
      out_ovf_nxt   = 1'b0;
      ml_nxt        = res_len;
      if (res_len >= plen_r) begin
        pos           = (idx1 >= plen_ext) ? INDEX_BITS'(idx1 - plen_ext) : '0;
        out_found_nxt = 1'b1;
        out_pos_nxt   = POS_W'(pos);
        found_nxt     = 1'b1;
        ml_nxt        = '0;
      end
      if (ti_r != '1) begin
        ti_nxt = ti_r + INDEX_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      pat_mem[plen_r[ADDR_W-1:0]]  <= byte_nxt;
      fail_mem[plen_r[ADDR_W-1:0]] <= res_len;
    end
    pat_q  <= pat_mem[rd_len[ADDR_W-1:0]];
    fail_q <= fail_mem[rd_len_m1[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      plen_r      <= '0;
      bpl_r       <= '0;
      ml_r        <= '0;
      ti_r        <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      plen_r      <= plen_nxt;
      bpl_r       <= bpl_nxt;
      ml_r        <= ml_nxt;
      ti_r        <= ti_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    byte_r      <= byte_nxt;
    len_r       <= len_nxt;
    out_found_r <= out_found_nxt;
    out_pos_r   <= out_pos_nxt;
    out_done_r  <= out_done_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_ovf_r, out_done_r, out_pos_r, out_found_r});

`ifndef NO_ASSERTIONS
  a_cmp_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CMP) |-> !out_valid_r)
    else $error("result slot busy while compare in flight");

  a_plen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    plen_r <= LEN_W'(MAX_PATTERN))
    else $error("pattern length beyond capacity");

  a_len_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CMP) |-> (len_r < plen_r))
    else $error("match length outside written pattern");

  a_found_reported: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(found_r) |-> (out_valid_r && out_found_r))
    else $error("match flag set without a reported match");
`endif

endmodule
